@@ design/paq_pkg.sv @@
// Shared types and constants for the priority array queue.
// Holds the request/result payload structs, command codes and the sequencer states.
// No dependencies.
`default_nettype none

package paq_pkg;

  localparam int CapW = 5;
  localparam int CountW = 5;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_PPOP   = 3'd2;
  localparam logic [2:0] ACT_ROTATE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  typedef struct packed {
    logic        [2:0]  action;
    logic signed [31:0] value_in;
    logic signed [31:0] priority_in;
  } paq_in_t;

  typedef struct packed {
    logic signed [31:0]       value_out;
    logic                     valid_res;
    logic        [CountW-1:0] count;
    logic                     empty_res;
    logic                     full_res;
  } paq_out_t;

  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] val;
  } paq_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT,
    ST_TAIL,
    ST_RESP
  } paq_state_t;

endpackage

`default_nettype wire

@@ design/priority_array_queue.sv @@
// Priority array queue: a bounded queue of value/priority pairs in arrival order, with
// push, FIFO pop, priority pop (ties to the oldest), rotate and clear. One request gives
// one result. A push, a clear, an unknown action or a pop of an empty queue goes from
// decode straight to the response. Any pop or rotate of a non-empty queue also passes
// the scan, shift and tail states. The entry memory gives one read and one write per
// cycle, so the scan and the compaction go one entry per cycle. A finished result sits
// in an output register, so the next request is taken while it waits. The block stalls
// only when a second result is ready before the first one is taken.
// Depends on paq_pkg, paq_ctrl and paq_store.
`default_nettype none

module priority_array_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire paq_pkg::paq_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output paq_pkg::paq_out_t              out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [paq_pkg::CapW-1:0]  cfg_data
);
  import paq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CapW-1:0] cap_r;
  logic out_valid_r;
  paq_out_t out_data_r;

  logic idle, done, res_take;
  paq_out_t res;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  paq_entry_t mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign res_take  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CapW'(16);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (done && res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  paq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid),
    .cmd       (in_data),
    .cap       (cap_r),
    .res_take  (res_take),
    .idle      (idle),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  paq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

@@ design/paq_store.sv @@
// Entry memory of the priority array queue: one write port, one registered read port.
// Depends on paq_pkg for the entry type.
`default_nettype none

module paq_store #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire paq_pkg::paq_entry_t        wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output paq_pkg::paq_entry_t             rdata
);
  import paq_pkg::*;

  paq_entry_t mem [DEPTH];
  paq_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/paq_ctrl.sv @@
// Command sequencer of the priority array queue: decodes a request, scans the entry
// memory for the oldest or the highest-priority entry, compacts the entries and forms
// the result. Depends on paq_pkg; drives the ports of paq_store.
`default_nettype none

module paq_ctrl #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire paq_pkg::paq_in_t           cmd,
  input  wire logic [paq_pkg::CapW-1:0]   cap,
  input  wire logic                       res_take,
  output logic                            idle,
  output logic                            done,
  output paq_pkg::paq_out_t               res,
  output logic                            mem_we,
  output logic [$clog2(DEPTH)-1:0]        mem_waddr,
  output paq_pkg::paq_entry_t             mem_wdata,
  output logic [$clog2(DEPTH)-1:0]        mem_raddr,
  input  wire paq_pkg::paq_entry_t        mem_rdata
);
  import paq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CapW) ? CW : CapW;

  paq_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  paq_in_t cmd_r, cmd_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  paq_entry_t best_r, best_nxt;
  logic [CW-1:0] sh_idx_r, sh_idx_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic pend_r, pend_nxt;
  logic signed [31:0] res_v_r, res_v_nxt;
  logic res_ok_r, res_ok_nxt;

  logic [LW-1:0] lim;
  logic [CW-1:0] last_idx;
  logic take;

  // The effective limit is the smaller of the capacity register and the depth.
  assign lim = (LW'(cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap);
  assign last_idx = (cmd_r.action == ACT_PPOP) ? cnt_r - CW'(1) : '0;
  assign take = (cmp_idx_r == '0) || (mem_rdata.prio > best_r.prio);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    sh_idx_r   <= sh_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    res_v_r    <= res_v_nxt;
    res_ok_r   <= res_ok_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_idx_nxt  = cmp_idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    sh_idx_nxt   = sh_idx_r;
    wr_idx_nxt   = wr_idx_r;
    pend_nxt     = pend_r;
    res_v_nxt    = res_v_r;
    res_ok_nxt   = res_ok_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;
    idle         = 1'b0;
    done         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          cmd_nxt   = cmd;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_v_nxt  = '0;
        res_ok_nxt = 1'b0;
        state_nxt  = ST_RESP;
        case (cmd_r.action)
          ACT_PUSH: begin
            if (LW'(cnt_r) < lim) begin
              mem_we     = 1'b1;
              mem_waddr  = cnt_r[AW-1:0];
              mem_wdata  = '{prio: cmd_r.priority_in, val: cmd_r.value_in};
              cnt_nxt    = cnt_r + CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          ACT_POP, ACT_PPOP, ACT_ROTATE: begin
            if (cnt_r != '0) begin
              mem_raddr   = '0;
              rd_idx_nxt  = CW'(1);
              cmp_idx_nxt = '0;
              state_nxt   = ST_SCAN;
            end
          end
          ACT_CLEAR: begin
            cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      // One entry is compared per cycle while the next one is read.
      // Plain pop and rotate stop after the oldest entry.
      ST_SCAN: begin
        mem_raddr = rd_idx_r[AW-1:0];
        rd_idx_nxt = rd_idx_r + CW'(1);
        if (take) begin
          best_nxt     = mem_rdata;
          best_idx_nxt = cmp_idx_r[AW-1:0];
        end
        if (cmp_idx_r == last_idx) begin
          sh_idx_nxt = CW'(take ? cmp_idx_r[AW-1:0] : best_idx_r) + CW'(1);
          pend_nxt   = 1'b0;
          state_nxt  = ST_SHIFT;
        end else begin
          cmp_idx_nxt = cmp_idx_r + CW'(1);
        end
      end

      // Entries above the removed one move down by one: read here, written the next cycle.
      ST_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = mem_rdata;
        end
        if (sh_idx_r < cnt_r) begin
          mem_raddr  = sh_idx_r[AW-1:0];
          wr_idx_nxt = AW'(sh_idx_r - CW'(1));
          sh_idx_nxt = sh_idx_r + CW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_TAIL;
        end
      end

      ST_TAIL: begin
        res_v_nxt  = best_r.val;
        res_ok_nxt = 1'b1;
        if (cmd_r.action == ACT_ROTATE) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_r - CW'(1));
          mem_wdata = best_r;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        done = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.value_out = res_v_r;
    res.valid_res = res_ok_r;
    res.count     = CountW'(cnt_r);
    res.empty_res = (cnt_r == '0);
    res.full_res  = (LW'(cnt_r) >= lim);
  end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for priority_array_queue: a queue-fed driver, a checking monitor
// and a model of the queue that predicts every result. Depends on paq_pkg.

module testbench;
  import paq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int LONG_HOLD = 500;
  localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] ACT_RESERVED_MID = 3'd6;
  localparam logic [2:0] ACT_RESERVED_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  paq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  paq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CapW-1:0] cfg_data = '0;

  // Model of the queue contents, oldest entry at index 0.
  logic signed [31:0] entry_vals [DEPTH];
  logic signed [31:0] entry_prios [DEPTH];
  int held_count = 0;
  logic [CapW-1:0] capacity_reg = CapW'(16);

  paq_in_t command_queue[$];
  paq_out_t predicted_status[$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 8;
  int gap_left = 0;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int rx_cycle = 0;

  priority_array_queue #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void remove_entry(int idx);
    for (int i = idx + 1; i < held_count; i++) begin
      entry_vals[i - 1] = entry_vals[i];
      entry_prios[i - 1] = entry_prios[i];
    end
    held_count--;
  endfunction

  // Applies one request to the model and returns the status it should report.
  function automatic paq_out_t apply_command(paq_in_t cmd);
    paq_out_t res;
    int lim;
    int best;
    logic signed [31:0] v;
    logic signed [31:0] p;
    res = '0;
    lim = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
    case (cmd.action)
      ACT_PUSH: begin
        if (held_count < lim) begin
          entry_vals[held_count] = cmd.value_in;
          entry_prios[held_count] = cmd.priority_in;
          held_count++;
          res.valid_res = 1'b1;
        end
      end
      ACT_POP: begin
        if (held_count > 0) begin
          res.value_out = entry_vals[0];
          res.valid_res = 1'b1;
          remove_entry(0);
        end
      end
      ACT_PPOP: begin
        if (held_count > 0) begin
          best = 0;
          // Strict greater-than keeps the oldest of equal priorities.
          for (int i = 1; i < held_count; i++) begin
            if (entry_prios[i] > entry_prios[best]) best = i;
          end
          res.value_out = entry_vals[best];
          res.valid_res = 1'b1;
          remove_entry(best);
        end
      end
      ACT_ROTATE: begin
        if (held_count > 0) begin
          v = entry_vals[0];
          p = entry_prios[0];
          remove_entry(0);
          entry_vals[held_count] = v;
          entry_prios[held_count] = p;
          held_count++;
          res.value_out = v;
          res.valid_res = 1'b1;
        end
      end
      ACT_CLEAR: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    res.count = CountW'(held_count);
    res.empty_res = (held_count == 0);
    res.full_res = (held_count >= lim);
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic add_command(logic [2:0] act, logic signed [31:0] v, logic signed [31:0] p);
    paq_in_t cmd;
    cmd.action = act;
    cmd.value_in = v;
    cmd.priority_in = p;
    command_queue.push_back(cmd);
  endtask

  // Runs of push-heavy and pop-heavy traffic so the queue fills and empties often.
  task automatic add_random_commands(int n);
    int fill_bias;
    int roll;
    int pick;
    logic signed [31:0] pr;
    fill_bias = 60;
    for (int k = 0; k < n; k++) begin
      if (k % 24 == 0) fill_bias = $urandom_range(20, 85);
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (pick < 5) pr = $urandom;
      else if (pick < 9) pr = int'($urandom_range(0, 6)) - 3;
      else pr = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      if (roll < 2) begin
        add_command(ACT_CLEAR, $urandom, $urandom);
      end else if (roll < 4) begin
        add_command(3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST)), $urandom, pr);
      end else if (roll < fill_bias) begin
        add_command(ACT_PUSH, $urandom, pr);
      end else begin
        pick = $urandom_range(0, 2);
        if (pick == 0) add_command(ACT_POP, $urandom, pr);
        else if (pick == 1) add_command(ACT_PPOP, $urandom, pr);
        else add_command(ACT_ROTATE, $urandom, pr);
      end
    end
  endtask

  task automatic wait_until_idle();
    while (command_queue.size() != 0 || in_valid || predicted_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CapW-1:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_reg = cap;
    cfg_valid <= 1'b0;
  endtask

  // Sender: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_status.push_back(apply_command(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (command_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= command_queue.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls on a pattern picked by bits 9:8 of rx_cycle.
  always @(posedge clk) begin : receive_side
    paq_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          error_count++;
        end else begin
          want = predicted_status.pop_front();
          compare_field("value_out", want.value_out, out_data.value_out);
          compare_field("valid_res", 32'(want.valid_res), 32'(out_data.valid_res));
          compare_field("count", 32'(want.count), 32'(out_data.count));
          compare_field("empty_res", 32'(want.empty_res), 32'(out_data.empty_res));
          compare_field("full_res", 32'(want.full_res), 32'(out_data.full_res));
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= 1'($urandom_range(0, 1));
          2'd2: out_ready <= (rx_cycle[2:0] != 3'd0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("priority_array_queue test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty operations, extreme values, priority ties, reserved actions and clear.
    add_command(ACT_POP, $urandom, $urandom);
    add_command(ACT_PPOP, $urandom, $urandom);
    add_command(ACT_ROTATE, $urandom, $urandom);
    add_command(ACT_PUSH, 32'sh80000000, 32'sh7fffffff);
    add_command(ACT_PUSH, 32'sh7fffffff, 32'sh80000000);
    add_command(ACT_PUSH, -32'sd1, -32'sd1);
    add_command(ACT_PUSH, 32'sd0, 32'sh7fffffff);
    add_command(ACT_PUSH, 32'sd12345, 32'sd0);
    add_command(ACT_PPOP, $urandom, $urandom);
    add_command(ACT_PPOP, $urandom, $urandom);
    add_command(ACT_ROTATE, $urandom, $urandom);
    add_command(ACT_ROTATE, $urandom, $urandom);
    add_command(ACT_POP, $urandom, $urandom);
    add_command(ACT_RESERVED_FIRST, $urandom, $urandom);
    add_command(ACT_RESERVED_MID, $urandom, $urandom);
    add_command(ACT_RESERVED_LAST, $urandom, $urandom);
    add_command(ACT_PPOP, $urandom, $urandom);
    add_command(ACT_CLEAR, $urandom, $urandom);
    add_command(ACT_POP, $urandom, $urandom);
    add_command(ACT_PUSH, $urandom, $urandom);
    add_command(ACT_CLEAR, $urandom, $urandom);
    add_command(ACT_PPOP, $urandom, $urandom);
    wait_until_idle();

    // A single entry of room.
    write_capacity(CapW'(1));
    add_command(ACT_PUSH, $urandom, $urandom);
    add_command(ACT_PUSH, $urandom, $urandom);
    add_command(ACT_ROTATE, $urandom, $urandom);
    add_command(ACT_PPOP, $urandom, $urandom);
    wait_until_idle();

    // No room at all: every push is dropped.
    write_capacity(CapW'(0));
    add_command(ACT_PUSH, $urandom, $urandom);
    add_command(ACT_PPOP, $urandom, $urandom);
    add_command(ACT_ROTATE, $urandom, $urandom);
    wait_until_idle();

    // A capacity above the array depth is limited by the depth.
    write_capacity(CapW'(31));
    for (int k = 0; k < DEPTH + 1; k++) add_command(ACT_PUSH, $urandom, $urandom_range(0, 3));
    add_command(ACT_PPOP, $urandom, $urandom);
    add_command(ACT_ROTATE, $urandom, $urandom);
    wait_until_idle();

    // Lowering the capacity below the count keeps the entries.
    write_capacity(CapW'(3));
    add_command(ACT_PUSH, $urandom, $urandom);
    for (int k = 0; k < DEPTH; k++) add_command(ACT_PPOP, $urandom, $urandom);
    add_command(ACT_PUSH, $urandom, $urandom);
    wait_until_idle();

    write_capacity(CapW'(16));
    hold_off_req = 1'b1;
    add_random_commands(450);
    wait_until_idle();
    write_capacity(CapW'(5));
    add_random_commands(200);
    wait_until_idle();
    write_capacity(CapW'(31));
    add_random_commands(250);
    wait_until_idle();
    write_capacity(CapW'(2));
    add_random_commands(100);
    wait_until_idle();
    for (int k = 0; k < 3; k++) begin
      write_capacity(CapW'($urandom_range(0, 31)));
      if (k == 1) hold_off_req = 1'b1;
      add_random_commands(120);
      wait_until_idle();
    end
    write_capacity(CapW'(16));
    add_random_commands(150);
    wait_until_idle();

    if (error_count == 0) begin
      $display("priority_array_queue test passed");
    end else begin
      $display("priority_array_queue test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/paq_pkg.sv
design/paq_store.sv
design/paq_ctrl.sv
design/priority_array_queue.sv
tb/sv/testbench.sv
